// ===== hw/rtl/fds_pkg.sv =====
// Package: shared types and constants for the finite difference slope block.
`default_nettype none
package fds_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIFF_W = 33;

    // One result job: up to two divisions, optionally averaged, or a forced value.
    typedef enum logic [1:0] {
        JOB_ONE   = 2'd0,  // single quotient
        JOB_AVG   = 2'd1,  // average of two quotients
        JOB_FORCE = 2'd2   // short series: saturate, flag error
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [DIFF_W-1:0] dy_a;
        logic [DIFF_W-1:0] dx_a;
        logic [DIFF_W-1:0] dy_b;
        logic [DIFF_W-1:0] dx_b;
        logic              last;
    } job_t;

    typedef struct packed {
        logic [DATA_W-1:0] slope;
        logic              error_flag;
        logic              last_result;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fds_stream_if.sv =====
// Interface: valid/ready channel carrying a packed payload.
`default_nettype none
interface fds_stream_if #(
    parameter int unsigned WIDTH = 1
) (
    input wire logic clk
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fds_front.sv =====
// Front end: sample window, point counting and job classification.
`default_nettype none
module fds_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   x_sample,
    input  wire logic [31:0]   y_sample,
    input  wire logic          last_point,
    output logic               job_valid,
    input  wire logic          job_ready,
    output fds_pkg::job_t      job
);
    import fds_pkg::*;

    logic [31:0] x_older_reg, x_newer_reg, y_older_reg, y_newer_reg;
    logic [1:0]  seen_reg;
    // Pending second job for a final item
    logic        hold_reg;
    job_t        hold_job_reg;

    job_t first_job, second_job;
    logic has_first, has_second;

    function automatic logic [DIFF_W-1:0] sub(input logic [31:0] b, input logic [31:0] a);
        sub = {b[31], b} - {a[31], a};
    endfunction

    always_comb
    begin
        first_job  = '0;
        second_job = '0;
        has_first  = 1'b0;
        has_second = 1'b0;
        if (!last_point)
        begin
            has_first = (seen_reg != 2'd0);
            first_job.kind = (seen_reg == 2'd2) ? JOB_AVG : JOB_ONE;
            if (seen_reg == 2'd3)
            begin
                first_job.dy_a = sub(y_sample, y_older_reg);
                first_job.dx_a = sub(x_sample, x_older_reg);
            end
            else
            begin
                first_job.dy_a = sub(y_sample, y_newer_reg);
                first_job.dx_a = sub(x_sample, x_newer_reg);
            end
            first_job.dy_b = sub(y_sample, y_older_reg);
            first_job.dx_b = sub(x_sample, x_older_reg);
        end
        else if (seen_reg == 2'd0)
        begin
            has_first       = 1'b1;
            first_job.kind  = JOB_FORCE;
            first_job.last  = 1'b1;
        end
        else if (seen_reg != 2'd3)
        begin
            has_first        = 1'b1;
            has_second       = 1'b1;
            first_job.kind   = JOB_FORCE;
            second_job.kind  = JOB_FORCE;
            second_job.last  = 1'b1;
        end
        else
        begin
            has_first       = 1'b1;
            has_second      = 1'b1;
            first_job.kind  = JOB_AVG;
            first_job.dy_a  = sub(y_sample, y_older_reg);
            first_job.dx_a  = sub(x_sample, x_older_reg);
            first_job.dy_b  = sub(y_newer_reg, y_older_reg);
            first_job.dx_b  = sub(x_newer_reg, x_older_reg);
            second_job.kind = JOB_ONE;
            second_job.dy_a = sub(y_sample, y_newer_reg);
            second_job.dx_a = sub(x_sample, x_newer_reg);
            second_job.last = 1'b1;
        end
    end

    assign in_ready  = !hold_reg && (job_ready || !has_first);
    assign job_valid = hold_reg || (in_valid && has_first);
    assign job       = hold_reg ? hold_job_reg : first_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_older_reg <= '0;
            x_newer_reg <= '0;
            y_older_reg <= '0;
            y_newer_reg <= '0;
            seen_reg    <= '0;
            hold_reg    <= 1'b0;
        end
        else
        begin
            if (hold_reg && job_ready)
                hold_reg <= 1'b0;
            if (in_valid && in_ready)
            begin
                if (last_point)
                begin
                    x_older_reg <= '0;
                    x_newer_reg <= '0;
                    y_older_reg <= '0;
                    y_newer_reg <= '0;
                    seen_reg    <= '0;
                end
                else
                begin
                    x_older_reg <= x_newer_reg;
                    y_older_reg <= y_newer_reg;
                    x_newer_reg <= x_sample;
                    y_newer_reg <= y_sample;
                    if (seen_reg != 2'd3)
                        seen_reg <= seen_reg + 2'd1;
                end
                hold_reg <= has_second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_job_reg <= second_job;
    end

`ifndef SYNTH
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> !in_ready) else $error("input taken while second job pending");
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> hold_job_reg.last) else $error("pending job not final");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_point) |=> (seen_reg == 2'd0))
        else $error("window not cleared");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/fds_queue.sv =====
// Two-entry queue between front and back ends.
`default_nettype none
module fds_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  fds_pkg::job_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output fds_pkg::job_t rd_data
);
    import fds_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       wr_fire, rd_fire;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_fire)
                wptr_reg <= !wptr_reg;
            if (rd_fire)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, wr_fire} - {1'b0, rd_fire};
        end
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !rd_ready) |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg))
        else $error("pointer mismatch");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/fds_back.sv =====
// Back end: radix-2 restoring divider, saturation, averaging and output register.
`default_nettype none
module fds_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  fds_pkg::job_t      job,
    output logic               res_valid,
    input  wire logic          res_ready,
    output fds_pkg::result_t   res
);
    import fds_pkg::*;

    localparam int unsigned NUM_W = DIFF_W + FRAC_BITS;     // dividend width
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t           state_reg;
    job_t             job_reg;
    logic             second_reg;       // working on divide b
    logic [NUM_W-1:0] num_reg;          // shifting dividend, collects quotient
    logic [DIFF_W-1:0] rem_reg;
    logic [DIFF_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg, zero_reg, dypos_reg;
    logic [32:0]      qa_reg;           // first saturated quotient, signed 33
    logic             err_reg;
    result_t          res_reg;
    logic             res_valid_reg;

    logic [DIFF_W-1:0] dy_sel, dx_sel, ady, adx;
    logic [DIFF_W:0]   trial;
    logic [DIFF_W-1:0] rem_sh;
    logic [32:0]       q_sat;
    logic [33:0]       avg_sum;
    logic [33:0]       avg_adj;
    logic [32:0]       avg;
    logic              out_free;

    assign dy_sel = second_reg ? job_reg.dy_b : job_reg.dy_a;
    assign dx_sel = second_reg ? job_reg.dx_b : job_reg.dx_a;
    assign ady = dy_sel[DIFF_W-1] ? (~dy_sel + 1'b1) : dy_sel;
    assign adx = dx_sel[DIFF_W-1] ? (~dx_sel + 1'b1) : dx_sel;

    assign rem_sh = {rem_reg[DIFF_W-2:0], num_reg[NUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, den_reg};

    // Saturation of the finished quotient (magnitude in num_reg)
    always_comb
    begin
        if (zero_reg)
            q_sat = dypos_reg ? 33'h0_7FFF_FFFF :
                    (dy_sel[DIFF_W-1] ? 33'h1_8000_0000 : 33'h0);
        else if (neg_reg)
            q_sat = (num_reg > NUM_W'(33'h0_8000_0000)) ? 33'h1_8000_0000 :
                    (~{1'b0, num_reg[31:0]} + 33'd1);
        else
            q_sat = (num_reg > NUM_W'(33'h0_7FFF_FFFF)) ? 33'h0_7FFF_FFFF :
                    {1'b0, num_reg[31:0]};
    end

    assign avg_sum = {qa_reg[32], qa_reg} + {q_sat[32], q_sat};
    assign avg_adj = avg_sum + {33'd0, avg_sum[33]};   // truncate toward zero
    assign avg     = avg_adj[33:1];

    assign out_free  = !res_valid_reg || res_ready;
    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready && state_reg != S_OUT)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        second_reg <= 1'b0;
                        state_reg  <= (job.kind == JOB_FORCE) ? S_OUT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_LAST)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (job_reg.kind == JOB_AVG && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath: no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg <= job;
                err_reg <= 1'b0;
                cnt_reg <= '0;
                if (job.kind == JOB_FORCE)
                    qa_reg <= 33'h0_7FFF_FFFF;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    // load operands for this division
                    num_reg   <= {ady, {FRAC_BITS{1'b0}}};
                    rem_reg   <= '0;
                    den_reg   <= adx;
                    neg_reg   <= dy_sel[DIFF_W-1] ^ dx_sel[DIFF_W-1];
                    zero_reg  <= (dx_sel == '0);
                    dypos_reg <= !dy_sel[DIFF_W-1] && (dy_sel != '0);
                    cnt_reg   <= cnt_reg + 1'b1;
                end
                else
                begin
                    if (!trial[DIFF_W])
                    begin
                        rem_reg <= trial[DIFF_W-1:0];
                        num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_reg <= (cnt_reg == CNT_LAST) ? cnt_reg : cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                cnt_reg <= '0;
                err_reg <= err_reg | zero_reg;
                if (!second_reg)
                    qa_reg <= q_sat;
                else
                    qa_reg <= avg;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_reg.slope       <= qa_reg[31:0];
                    res_reg.error_flag  <= err_reg || (job_reg.kind == JOB_FORCE);
                    res_reg.last_result <= job_reg.last;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= CNT_LAST)) else $error("count overrun");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/finite_difference_slope.sv =====
// Top level: finite difference slope over a stream of Q16.16 points.
// Usage
//   in  : sink channel, payload {x_sample, y_sample, last_point}; a transfer
//         is one sample point. last_point closes the series.
//   out : source channel, payload {slope, error_flag, last_result}.
//   Slopes come one point behind the input: no result for the first point,
//   one per later point, two for the final point of a multi-point series (second has last_result).
//   A single-point or under-four-point series gives saturated slopes with
//   error_flag set on the final point's results; zero dx saturates by sign.
// Timing
//   The back end runs a restoring divider, one quotient bit per cycle over
//   33+FRAC_BITS bits after an operand load. An averaged result runs two
//   divisions in turn; a forced short-series result skips the divider. The
//   divider takes a new job only once its last result is registered.
// Stall and reset
//   A two-deep job queue parts the front end from the divider, so points are
//   taken while the divider works; an output register holds a result until
//   the receiver takes it; a next result waits in the divider meanwhile.
//   Async reset clears the window, queue and output valid.
`default_nettype none
module finite_difference_slope #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fds_stream_if.sink   in,
    fds_stream_if.source out
);
    import fds_pkg::*;

    logic    fr_valid, fr_ready;
    job_t    fr_job;
    logic    bk_valid, bk_ready;
    job_t    bk_job;
    result_t res;

    // in.data = {x_sample, y_sample, last_point}
    fds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in.valid),
        .in_ready   (in.ready),
        .x_sample   (in.data[64:33]),
        .y_sample   (in.data[32:1]),
        .last_point (in.data[0]),
        .job_valid  (fr_valid),
        .job_ready  (fr_ready),
        .job        (fr_job)
    );

    fds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_job),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_data  (bk_job)
    );

    fds_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job       (bk_job),
        .res_valid (out.valid),
        .res_ready (out.ready),
        .res       (res)
    );

    // out.data = {slope, error_flag, last_result}
    assign out.data = {res.slope, res.error_flag, res.last_result};

`ifndef SYNTH
    a_out_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> $stable(out.data))
        else $error("output data changed under stall");
    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> out.valid) else $error("output valid dropped");
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> !$isunknown(out.data))
        else $error("unknown result data");
`endif
endmodule
`default_nettype wire

// ===== sim/fds_tb_pkg.sv =====
// Package: testbench-side input item type for the slope block.
package fds_tb_pkg;
    typedef struct packed {
        logic [31:0] x_sample;
        logic [31:0] y_sample;
        logic        last_point;
    } point_t;
endpackage

// ===== sim/testbench.sv =====
// Testbench: random and directed point series checked against a slope predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fds_pkg::*;
    import fds_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   failed = 1'b0;

    always #5 clk = ~clk;

    fds_stream_if #(.WIDTH(65)) pts (.clk(clk));
    fds_stream_if #(.WIDTH(34)) res (.clk(clk));

    finite_difference_slope #(.FRAC_BITS(16)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in(pts.sink),
        .out(res.source)
    );

    // Predictor state: sliding window of the last two points.
    logic signed [31:0] win_x_old, win_x_new, win_y_old, win_y_new;
    int unsigned        held_points;
    result_t            expected_slopes[$];

    // Receiver stall control.
    int  hold_off_cycles = 0;
    int  stall_pct = 30;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Fixed-point quotient of exact differences; saturates, flags zero dx.
    function automatic logic signed [63:0] quotient(input logic signed [63:0] dy,
                                                    input logic signed [63:0] dx,
                                                    inout bit err);
        logic [63:0] ay, ax, q;
        bit neg;
        if (dx == 0)
        begin
            err = 1'b1;
            return (dy > 0) ? SAT_HI : (dy < 0) ? SAT_LO : 64'sd0;
        end
        neg = (dy < 0) != (dx < 0);
        ay = (dy < 0) ? -dy : dy;
        ax = (dx < 0) ? -dx : dx;
        q = (ay << 16) / ax;
        if (neg)
        begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -$signed(q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return $signed(q);
    endfunction

    function automatic logic signed [63:0] slope_between(input logic signed [31:0] xa,
        input logic signed [31:0] ya, input logic signed [31:0] xb,
        input logic signed [31:0] yb, inout bit err);
        logic signed [63:0] dy, dx;
        dy = 64'(yb) - 64'(ya);
        dx = 64'(xb) - 64'(xa);
        return quotient(dy, dx, err);
    endfunction

    function automatic result_t make_result(input logic signed [63:0] s, input bit err,
                                            input bit lst);
        result_t r;
        r.slope = s[31:0];
        r.error_flag = err;
        r.last_result = lst;
        return r;
    endfunction

    // Queue the slopes that one accepted point causes, then advance the window.
    task automatic predict_slopes(input point_t p);
        logic signed [31:0] xc, yc;
        logic signed [63:0] a, b;
        bit e1, e2;
        xc = p.x_sample;
        yc = p.y_sample;
        e1 = 0;
        e2 = 0;
        if (!p.last_point)
        begin
            if (held_points == 1)
            begin
                a = slope_between(win_x_new, win_y_new, xc, yc, e1);
                expected_slopes.push_back(make_result(a, e1, 0));
            end
            else if (held_points == 2)
            begin
                // second point: mean of forward and central differences
                a = slope_between(win_x_new, win_y_new, xc, yc, e1);
                b = slope_between(win_x_old, win_y_old, xc, yc, e1);
                expected_slopes.push_back(make_result((a + b) / 2, e1, 0));
            end
            else if (held_points >= 3)
            begin
                a = slope_between(win_x_old, win_y_old, xc, yc, e1);
                expected_slopes.push_back(make_result(a, e1, 0));
            end
            win_x_old = win_x_new;
            win_y_old = win_y_new;
            win_x_new = xc;
            win_y_new = yc;
            if (held_points < 3) held_points++;
            return;
        end
        if (held_points == 0)
            expected_slopes.push_back(make_result(SAT_HI, 1, 1));
        else if (held_points < 3)
        begin
            // short series: both closing slopes forced
            expected_slopes.push_back(make_result(SAT_HI, 1, 0));
            expected_slopes.push_back(make_result(SAT_HI, 1, 1));
        end
        else
        begin
            a = slope_between(win_x_old, win_y_old, xc, yc, e1);
            b = slope_between(win_x_old, win_y_old, win_x_new, win_y_new, e1);
            expected_slopes.push_back(make_result((a + b) / 2, e1, 0));
            a = slope_between(win_x_new, win_y_new, xc, yc, e2);
            expected_slopes.push_back(make_result(a, e2, 1));
        end
        win_x_old = 0;
        win_x_new = 0;
        win_y_old = 0;
        win_y_new = 0;
        held_points = 0;
    endtask

    // Sender: offer one point, wait for its transfer; random gaps between bursts.
    int burst_left = 0;
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit lst);
        point_t p;
        p.x_sample = x;
        p.y_sample = y;
        p.last_point = lst;
        if (burst_left == 0)
            burst_left = $urandom_range(1, 12);
        burst_left--;
        pts.valid <= 1'b1;
        pts.data  <= p;
        do @(posedge clk); while (!pts.ready);
        predict_slopes(p);
        if (burst_left == 0)
        begin
            // end of burst: idle gap
            pts.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // Receiver stall pattern; a long hold-off overrides it.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && res.valid && res.ready)
        begin
            got = res.data;
            if (expected_slopes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_slopes.pop_front();
                if (got.slope !== want.slope)
                begin
                    $display("%0t: slope expected %h actual %h", $time, want.slope, got.slope);
                    failed = 1'b1;
                end
                if (got.error_flag !== want.error_flag)
                begin
                    $display("%0t: error_flag expected %b actual %b", $time,
                             want.error_flag, got.error_flag);
                    failed = 1'b1;
                end
                if (got.last_result !== want.last_result)
                begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             want.last_result, got.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // Directed series: extremes, zero spacing, single-point and short series.
    task automatic test_directed();
        send_point(32'h1234, 32'h5678, 1);                   // lone point
        send_point(0, 0, 0);
        send_point(32'h10000, 32'h7FFF_FFFF, 1);              // two points
        send_point(0, 0, 0);
        send_point(0, 32'h10000, 0);
        send_point(32'h20000, 32'h8000_0000, 1);              // three points, zero dx
        send_point(32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);          // zero dx and dy
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < 6; i++)
            send_point(32'(i) << 16, 32'(i * i) << 16, i == 5);
        for (int i = 0; i < 4; i++)
            send_point(32'h0001_0000, 32'(i), i == 3);        // all spacing zero
    endtask

    // Random series, mostly ordered x with random content; some noise.
    task automatic test_random_series(input int points);
        int sent = 0;
        logic [31:0] x;
        int len;
        while (sent < points)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            x = $urandom;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    x = rand_word();
                else
                    x = x + $urandom_range(0, 3 << 16);
                send_point(x, rand_word(), i == len - 1);
                sent++;
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering points.
    task automatic test_backpressure();
        hold_off_cycles = 600;
        stall_pct = 0;
        test_random_series(40);
        stall_pct = 80;
        test_random_series(60);
        stall_pct = 30;
    endtask

    initial
    begin
        pts.valid = 1'b0;
        pts.data = '0;
        res.ready = 1'b0;
        win_x_old = 0;
        win_x_new = 0;
        win_y_old = 0;
        win_y_new = 0;
        held_points = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_series(950);
        pts.valid <= 1'b0;
        while (expected_slopes.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (!failed)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: ends a hung run with a mismatch report.
    initial
    begin
        #8ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/fds_pkg.sv
hw/rtl/fds_stream_if.sv
hw/rtl/fds_front.sv
hw/rtl/fds_queue.sv
hw/rtl/fds_back.sv
hw/rtl/finite_difference_slope.sv
sim/fds_tb_pkg.sv
sim/testbench.sv
